// File: sv/ngga_pkg.sv
package ngga_pkg;

    // Number format: ddmm.<FRACTION_DIGITS digits of minutes>
    localparam int FRACTION_DIGITS = 5;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int FIELD_W = 4;
    localparam int WHOLE_W = 17;
    localparam int FRAC_W  = $clog2(10 ** FRACTION_DIGITS);
    localparam int FDIG_W  = 3;
    localparam int LEN_W   = 3;
    localparam int OUT_W   = 35;

    // Conversion datapath widths
    localparam int DEG_W   = 10;
    localparam int MIN_W   = 7;
    localparam int X_W     = 30;
    localparam int Y_W     = X_W - 2;
    localparam int Q_W     = 24;
    localparam int DSC_W   = 34;

    // Characters of interest
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
    localparam logic [CHAR_W-1:0] CH_S     = 8'h53;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h57;

    // Comma counts that select the fields of interest
    localparam logic [FIELD_W-1:0] FIELD_LAT     = 4'd2;
    localparam logic [FIELD_W-1:0] FIELD_LAT_HEM = 4'd3;
    localparam logic [FIELD_W-1:0] FIELD_LON     = 4'd4;
    localparam logic [FIELD_W-1:0] FIELD_LON_HEM = 4'd5;
    localparam logic [FIELD_W-1:0] FIELD_MAX     = 4'd15;

    // Progress through the "GGA" tag
    typedef enum logic [2:0] {
        TAG_NONE = 3'b001,
        TAG_G    = 3'b010,
        TAG_GG   = 3'b100
    } ngga_tag_t;

    // Field presence bits
    localparam int PRES_LAT     = 0;
    localparam int PRES_LAT_HEM = 1;
    localparam int PRES_LON     = 2;
    localparam int PRES_LON_HEM = 3;
    localparam logic [3:0] PRES_ALL = 4'hF;

    localparam logic [LEN_W-1:0]   LEN_MAX     = 3'd7;
    localparam logic [LEN_W-1:0]   LEN_MIN     = 3'd4;
    localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = 17'd99999;
    localparam logic [OUT_W-1:0]   MAG_LIMIT   = 35'd9999999999;

    // Degrees in output units, and the minutes fill to seven digits
    localparam longint UNITS       = 10000000;
    localparam longint FILL_SCALE  = 10 ** (7 - FRACTION_DIGITS);
    localparam longint ROUND_HALF  = 30;

    // Reciprocal of 100 for whole < 2^17
    localparam longint DIV100_MUL   = 167773;
    localparam int     DIV100_SHIFT = 24;
    localparam int     DIV100_W     = WHOLE_W + 18;

    // Reciprocal of 15 for values < 2^28 (divide by 60 as >>2 then /15)
    localparam longint DIV15_MUL    = 286331154;
    localparam int     DIV15_SHIFT  = 32;
    localparam int     DIV15_W      = Y_W + 29;

    // Scan state of one number field
    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [FDIG_W-1:0]  fdig;
        logic [LEN_W-1:0]   len;
        logic               neg;
    } ngga_scan_t;

    // One coordinate handed to the converter
    typedef struct packed {
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [FDIG_W-1:0]  fdig;
        logic               short_f;
        logic               neg;
    } ngga_coord_t;

    // Stage load enables of the converter pipeline
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } ngga_stage_en_t;

    // 10^(FRACTION_DIGITS - fdig): pads a short fraction to full digits
    function automatic logic [FRAC_W-1:0] frac_scale(input logic [FDIG_W-1:0] fdig);
        logic [FRAC_W-1:0] p;
        p = FRAC_W'(1);
        for (int i = 0; i < FRACTION_DIGITS; i++) begin
            if (i + int'(fdig) < FRACTION_DIGITS) begin
                p = FRAC_W'(p * FRAC_W'(10));
            end
        end
        return p;
    endfunction

endpackage

// File: sv/ngga_lexer.sv
module ngga_lexer
    import ngga_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    input  logic [CHAR_W-1:0] rx_char,
    output logic              rx_stall,
    input  logic              line_ready,
    output logic              line_valid,
    output ngga_coord_t       line_lat,
    output ngga_coord_t       line_lon
);

    // Input register
    logic              char_valid_reg, char_valid_next;
    logic [CHAR_W-1:0] char_reg;

    // Line scan state
    logic [FIELD_W-1:0] field_position_reg, field_position_next;
    ngga_tag_t          tag_progress_reg, tag_progress_next;
    logic               tag_found_reg, tag_found_next;
    logic               line_nonempty_reg, line_nonempty_next;
    logic               number_stopped_reg, number_stopped_next;
    logic               in_fraction_reg, in_fraction_next;
    ngga_scan_t         lat_reg, lat_next;
    ngga_scan_t         lon_reg, lon_next;
    logic [3:0]         fields_present_reg, fields_present_next;

    // Line record
    logic               rec_valid_reg, rec_valid_next;
    ngga_coord_t        rec_lat_reg, rec_lon_reg;

    logic is_eol;
    logic is_digit;
    logic emit;
    logic take;

    // Advance one number field by one character
    function automatic ngga_scan_t number_step(
        input ngga_scan_t        s,
        input logic [CHAR_W-1:0] c,
        input logic              stopped,
        input logic              frac_mode
    );
        ngga_scan_t        r;
        logic [3:0]        d;
        logic [WHOLE_W+2:0] w;
        r = s;
        d = 4'(c - CH_ZERO);
        w = (WHOLE_W + 3)'(s.whole) * (WHOLE_W + 3)'(10) + (WHOLE_W + 3)'(d);
        if (s.len < LEN_MAX) begin
            r.len = s.len + LEN_W'(1);
        end
        if (!stopped && c >= CH_ZERO && c <= CH_NINE) begin
            if (!frac_mode) begin
                r.whole = (w > (WHOLE_W + 3)'(WHOLE_LIMIT)) ? WHOLE_LIMIT : WHOLE_W'(w);
            end else if (s.fdig < FDIG_W'(FRACTION_DIGITS)) begin
                r.frac = FRAC_W'(s.frac * FRAC_W'(10) + FRAC_W'(d));
                r.fdig = s.fdig + FDIG_W'(1);
            end
        end
        return r;
    endfunction

    function automatic ngga_coord_t to_coord(input ngga_scan_t s);
        ngga_coord_t r;
        r.whole   = s.whole;
        r.frac    = s.frac;
        r.fdig    = s.fdig;
        r.short_f = (s.len < LEN_MIN);
        r.neg     = s.neg;
        return r;
    endfunction

    assign is_eol   = (char_reg == CH_CR) || (char_reg == CH_LF);
    assign is_digit = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign emit     = is_eol && line_nonempty_reg && tag_found_reg
                      && (fields_present_reg == PRES_ALL);
    // Hold the word only when it closes a line to emit and the record slot cannot take it
    assign take     = char_valid_reg && (!emit || line_ready);
    assign rx_stall = char_valid_reg && !take;

    // Load the input register whenever it is free
    assign char_valid_next = rx_stall ? char_valid_reg : rx_valid;

    // Scan state update
    always_comb
    begin
        field_position_next = field_position_reg;
        tag_progress_next   = tag_progress_reg;
        tag_found_next      = tag_found_reg;
        line_nonempty_next  = line_nonempty_reg;
        number_stopped_next = number_stopped_reg;
        in_fraction_next    = in_fraction_reg;
        lat_next            = lat_reg;
        lon_next            = lon_reg;
        fields_present_next = fields_present_reg;
        if (take) begin
            if (is_eol) begin
                field_position_next = '0;
                tag_progress_next   = TAG_NONE;
                tag_found_next      = 1'b0;
                line_nonempty_next  = 1'b0;
                number_stopped_next = 1'b0;
                in_fraction_next    = 1'b0;
                lat_next            = '0;
                lon_next            = '0;
                fields_present_next = '0;
            end else begin
                line_nonempty_next = 1'b1;
                // Look for the tag anywhere in the line
                if (!tag_found_reg) begin
                    priority if (char_reg == CH_G) begin
                        tag_progress_next = (tag_progress_reg == TAG_NONE) ? TAG_G : TAG_GG;
                    end else if (char_reg == CH_A && tag_progress_reg == TAG_GG) begin
                        tag_found_next    = 1'b1;
                        tag_progress_next = TAG_NONE;
                    end else begin
                        tag_progress_next = TAG_NONE;
                    end
                end
                if (char_reg == CH_COMMA) begin
                    if (field_position_reg < FIELD_MAX) begin
                        field_position_next = field_position_reg + FIELD_W'(1);
                    end
                    number_stopped_next = 1'b0;
                    in_fraction_next    = 1'b0;
                end else begin
                    // Stop the number on any character that is not a digit or first dot
                    if ((field_position_reg == FIELD_LAT || field_position_reg == FIELD_LON)
                        && !number_stopped_reg && !is_digit) begin
                        if (char_reg == CH_DOT && !in_fraction_reg) begin
                            in_fraction_next = 1'b1;
                        end else begin
                            number_stopped_next = 1'b1;
                        end
                    end
                    unique case (field_position_reg)
                        FIELD_LAT:
                        begin
                            lat_next = number_step(lat_reg, char_reg,
                                                   number_stopped_reg, in_fraction_reg);
                            fields_present_next[PRES_LAT] = 1'b1;
                        end
                        FIELD_LAT_HEM:
                        begin
                            if (!fields_present_reg[PRES_LAT_HEM]) begin
                                lat_next.neg = (char_reg == CH_S) || (char_reg == CH_W);
                            end
                            fields_present_next[PRES_LAT_HEM] = 1'b1;
                        end
                        FIELD_LON:
                        begin
                            lon_next = number_step(lon_reg, char_reg,
                                                   number_stopped_reg, in_fraction_reg);
                            fields_present_next[PRES_LON] = 1'b1;
                        end
                        FIELD_LON_HEM:
                        begin
                            if (!fields_present_reg[PRES_LON_HEM]) begin
                                lon_next.neg = (char_reg == CH_S) || (char_reg == CH_W);
                            end
                            fields_present_next[PRES_LON_HEM] = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    // Record slot: fill on a finished line, drain when downstream takes it
    assign rec_valid_next = line_ready ? (take && emit) : rec_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_valid_reg     <= 1'b0;
            field_position_reg <= '0;
            tag_progress_reg   <= TAG_NONE;
            tag_found_reg      <= 1'b0;
            line_nonempty_reg  <= 1'b0;
            number_stopped_reg <= 1'b0;
            in_fraction_reg    <= 1'b0;
            lat_reg            <= '0;
            lon_reg            <= '0;
            fields_present_reg <= '0;
            rec_valid_reg      <= 1'b0;
        end else begin
            char_valid_reg     <= char_valid_next;
            field_position_reg <= field_position_next;
            tag_progress_reg   <= tag_progress_next;
            tag_found_reg      <= tag_found_next;
            line_nonempty_reg  <= line_nonempty_next;
            number_stopped_reg <= number_stopped_next;
            in_fraction_reg    <= in_fraction_next;
            lat_reg            <= lat_next;
            lon_reg            <= lon_next;
            fields_present_reg <= fields_present_next;
            rec_valid_reg      <= rec_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (!rx_stall) begin
            char_reg <= rx_char;
        end
        if (take && emit) begin
            rec_lat_reg <= to_coord(lat_reg);
            rec_lon_reg <= to_coord(lon_reg);
        end
    end

    assign line_valid = rec_valid_reg;
    assign line_lat   = rec_lat_reg;
    assign line_lon   = rec_lon_reg;

endmodule

// File: sv/ngga_convert.sv
module ngga_convert
    import ngga_pkg::*;
(
    input  logic                    clk,
    input  ngga_stage_en_t          en,
    input  ngga_coord_t             coord,
    output logic signed [OUT_W-1:0] result
);

    // Stage 2: degrees, whole minutes, fraction padded to full digits
    logic [DEG_W-1:0]    deg_reg, deg_next;
    logic [MIN_W-1:0]    min_reg, min_next;
    logic [FRAC_W-1:0]   fs_reg, fs_next;
    logic                short2_reg, neg2_reg;
    logic [DIV100_W-1:0] div100_prod;

    // Stage 3: scaled degrees and rounded minutes numerator
    logic [DSC_W-1:0]    dsc3_reg, dsc3_next;
    logic [X_W-1:0]      x_reg, x_next;
    logic                short3_reg, neg3_reg;

    // Stage 4: minutes over sixty
    logic [DSC_W-1:0]    dsc4_reg;
    logic [Q_W-1:0]      q_reg, q_next;
    logic                short4_reg, neg4_reg;
    logic [DIV15_W-1:0]  div15_prod;

    logic [OUT_W-1:0]    sum;
    logic [OUT_W-1:0]    mag;

    // Split ddmm by reciprocal multiply
    always_comb
    begin
        div100_prod = DIV100_W'(coord.whole) * DIV100_W'(DIV100_MUL);
        deg_next    = DEG_W'(div100_prod >> DIV100_SHIFT);
        min_next    = MIN_W'(coord.whole - WHOLE_W'(WHOLE_W'(deg_next) * WHOLE_W'(100)));
        fs_next     = FRAC_W'(coord.frac * frac_scale(coord.fdig));
    end

    // Form numerator of minutes * 1e7 / 60 with half-divisor rounding
    always_comb
    begin
        dsc3_next = DSC_W'(DSC_W'(deg_reg) * DSC_W'(UNITS));
        x_next    = X_W'(X_W'(min_reg) * X_W'(UNITS))
                    + X_W'(X_W'(fs_reg) * X_W'(FILL_SCALE))
                    + X_W'(ROUND_HALF);
    end

    // Divide by 60: drop two bits, then reciprocal of 15
    always_comb
    begin
        div15_prod = DIV15_W'(x_reg[X_W-1:2]) * DIV15_W'(DIV15_MUL);
        q_next     = Q_W'(div15_prod >> DIV15_SHIFT);
    end

    // Add, clamp, zero short fields, apply hemisphere
    always_comb
    begin
        sum = OUT_W'(dsc4_reg) + OUT_W'(q_reg);
        mag = (sum > MAG_LIMIT) ? MAG_LIMIT : sum;
        if (short4_reg) begin
            mag = '0;
        end
        result = neg4_reg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2) begin
            deg_reg    <= deg_next;
            min_reg    <= min_next;
            fs_reg     <= fs_next;
            short2_reg <= coord.short_f;
            neg2_reg   <= coord.neg;
        end
        if (en.s3) begin
            dsc3_reg   <= dsc3_next;
            x_reg      <= x_next;
            short3_reg <= short2_reg;
            neg3_reg   <= neg2_reg;
        end
        if (en.s4) begin
            dsc4_reg   <= dsc3_reg;
            q_reg      <= q_next;
            short4_reg <= short3_reg;
            neg4_reg   <= neg3_reg;
        end
    end

endmodule

// File: sv/nmea_gga_position_parser.sv
// NMEA GGA position parser. Takes one received character per word on the
// rx channel and accepts a new word every cycle while rx_stall is low;
// each character is decoded in the cycle after it lands in the input
// register. When a CR or LF closes a line that contains "GGA" and
// non-empty fields 3 to 6, one position word leaves on the pos channel,
// carrying latitude and longitude in signed units of 1e-7 degree. The
// conversion runs in a four-stage pipeline behind the scanner, so later
// lines keep streaming in while a result travels or waits; rx_stall rises
// only when a line end is ready to emit and every pipeline stage and the
// output register are full behind a stalled pos channel.
module nmea_gga_position_parser
    import ngga_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    rx_valid,
    output logic                    rx_stall,
    input  logic [CHAR_W-1:0]       rx_char,
    output logic                    pos_valid,
    input  logic                    pos_stall,
    output logic signed [OUT_W-1:0] latitude,
    output logic signed [OUT_W-1:0] longitude
);

    logic           line_valid;
    ngga_coord_t    line_lat, line_lon;
    ngga_stage_en_t stage_en;

    logic           v2_reg, v2_next;
    logic           v3_reg, v3_next;
    logic           v4_reg, v4_next;
    logic           pos_valid_reg, pos_valid_next;
    logic signed [OUT_W-1:0] latitude_reg, longitude_reg;
    logic signed [OUT_W-1:0] lat_result, lon_result;

    logic ready_out, ready4, ready3, ready2, ready1;

    // Backpressure chain: a stage takes a word when empty or draining
    assign ready_out = !pos_valid_reg || !pos_stall;
    assign ready4    = !v4_reg || ready_out;
    assign ready3    = !v3_reg || ready4;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !line_valid || ready2;

    assign stage_en.s2 = ready2 && line_valid;
    assign stage_en.s3 = ready3 && v2_reg;
    assign stage_en.s4 = ready4 && v3_reg;

    assign v2_next        = ready2 ? line_valid : v2_reg;
    assign v3_next        = ready3 ? v2_reg : v3_reg;
    assign v4_next        = ready4 ? v3_reg : v4_reg;
    assign pos_valid_next = ready_out ? v4_reg : pos_valid_reg;

    ngga_lexer u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_char    (rx_char),
        .rx_stall   (rx_stall),
        .line_ready (ready1),
        .line_valid (line_valid),
        .line_lat   (line_lat),
        .line_lon   (line_lon)
    );

    ngga_convert u_conv_lat (
        .clk    (clk),
        .en     (stage_en),
        .coord  (line_lat),
        .result (lat_result)
    );

    ngga_convert u_conv_lon (
        .clk    (clk),
        .en     (stage_en),
        .coord  (line_lon),
        .result (lon_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            pos_valid_reg <= 1'b0;
        end else begin
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            pos_valid_reg <= pos_valid_next;
        end
    end

    // Output register: load the finished word when the slot frees up
    always_ff @(posedge clk)
    begin
        if (ready_out && v4_reg) begin
            latitude_reg  <= lat_result;
            longitude_reg <= lon_result;
        end
    end

    assign pos_valid = pos_valid_reg;
    assign latitude  = latitude_reg;
    assign longitude = longitude_reg;

endmodule

// File: sv/ngga_checker.sv
module ngga_checker
    import ngga_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    rx_valid,
    input logic                    rx_stall,
    input logic                    pos_valid,
    input logic                    pos_stall,
    input logic signed [OUT_W-1:0] latitude,
    input logic signed [OUT_W-1:0] longitude
);

    // Hold a stalled result word
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && pos_stall |=> pos_valid)
        else $error("pos_valid dropped while stalled");

    a_pos_stable: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid && pos_stall |=> $stable(latitude) && $stable(longitude))
        else $error("result changed while stalled");

    // Input backs up only behind a stalled output
    a_rx_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        rx_stall |-> pos_valid && pos_stall)
        else $error("rx_stall without output backpressure");

    // Stall starts only on a word that was just taken
    a_rx_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rx_stall) |-> $past(rx_valid))
        else $error("rx_stall rose with no word taken");

    // Clamp keeps both coordinates within ten digits
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_valid |-> latitude <= 35'sd9999999999 && latitude >= -35'sd9999999999
                   && longitude <= 35'sd9999999999 && longitude >= -35'sd9999999999)
        else $error("coordinate out of range");

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (.*);
